FILE: rtl/vhc_pkg.sv
// shared constants, types and register indexes of the voxel hit-count filter
`timescale 1ns / 1ps
package vhc_pkg;

  // table geometry
  localparam int TABLE_DEPTH  = 4096;
  localparam int IDX_W        = $clog2(TABLE_DEPTH);
  localparam int CNT_W        = IDX_W + 1;
  localparam int STALE_FRAMES = 2000;

  // field widths
  localparam int COORD_BITS = 24;
  localparam int HIT_W      = 20;
  localparam int TOUCH_W    = 48;
  localparam int FRAME_W    = 32;
  localparam int VSIZE_W    = 16;
  localparam int RANGE_W    = 23;
  localparam int CAP_W      = 13;
  localparam int CMP_W      = (CNT_W > CAP_W) ? CNT_W : CAP_W;
  localparam int MUL_W      = (COORD_BITS > RANGE_W) ? COORD_BITS : RANGE_W;
  localparam int SQ_W       = 2 * MUL_W;
  localparam int R2_W       = SQ_W + 2;

  localparam logic [HIT_W-1:0] HIT_SAT = HIT_W'(1000000);

  // small command queue between front and back
  localparam int FIFO_DEPTH = 2;
  localparam int FIFO_PTR_W = $clog2(FIFO_DEPTH);
  localparam int FIFO_CNT_W = FIFO_PTR_W + 1;

  // configuration port
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 23;
  localparam logic [CFG_IDX_W-1:0] REG_FILTER_ENABLE    = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_SHADOW_EN        = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_MIN_STATIC_COUNT = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_VOXEL_SIZE_MM    = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_MIN_RANGE_MM     = 3'd4;
  localparam logic [CFG_IDX_W-1:0] REG_MAX_RANGE_MM     = 3'd5;
  localparam logic [CFG_IDX_W-1:0] REG_VOXEL_CAPACITY   = 3'd6;

  typedef struct packed {
    logic               filter_enable;
    logic               shadow_en;
    logic [HIT_W-1:0]   min_static_count;
    logic [VSIZE_W-1:0] voxel_size_mm;
    logic [RANGE_W-1:0] min_range_mm;
    logic [RANGE_W-1:0] max_range_mm;
    logic [CAP_W-1:0]   voxel_capacity;
  } cfg_t;

  typedef enum logic [1:0] {
    CMD_PASS  = 2'd0,
    CMD_POINT = 2'd1,
    CMD_FRAME = 2'd2
  } cmd_kind_t;

  typedef struct packed {
    cmd_kind_t             kind;
    logic                  keep;
    logic [COORD_BITS-1:0] key_x;
    logic [COORD_BITS-1:0] key_y;
    logic [COORD_BITS-1:0] key_z;
  } cmd_t;

  typedef struct packed {
    logic                  valid;
    logic [COORD_BITS-1:0] key_x;
    logic [COORD_BITS-1:0] key_y;
    logic [COORD_BITS-1:0] key_z;
    logic [HIT_W-1:0]      hits;
    logic [FRAME_W-1:0]    last_frame;
    logic [TOUCH_W-1:0]    touch;
  } entry_t;

endpackage

FILE: rtl/vhc_if.sv
// point and result channel interfaces
`timescale 1ns / 1ps
interface vhc_in_if;
  logic                                  valid;
  logic                                  ready;
  logic                                  operation;
  logic signed [vhc_pkg::COORD_BITS-1:0] point_x;
  logic signed [vhc_pkg::COORD_BITS-1:0] point_y;
  logic signed [vhc_pkg::COORD_BITS-1:0] point_z;

  modport source (output valid, operation, point_x, point_y, point_z, input ready);
  modport sink (input valid, operation, point_x, point_y, point_z, output ready);
endinterface

interface vhc_out_if;
  logic                          valid;
  logic                          ready;
  logic                          keep_point;
  logic                          is_static;
  logic                          in_range;
  logic [vhc_pkg::HIT_W-1:0]     hit_count;
  logic                          table_full;
  logic [vhc_pkg::CAP_W-1:0]     evicted_count;

  modport source (output valid, keep_point, is_static, in_range, hit_count, table_full,
                  evicted_count, input ready);
  modport sink (input valid, keep_point, is_static, in_range, hit_count, table_full,
                evicted_count, output ready);
endinterface

FILE: rtl/vhc_front.sv
// front end: range check with a shared multiplier and voxel keys by a serial divider
`timescale 1ns / 1ps
module vhc_front (
  input  logic          clk,
  input  logic          rst_n,
  input  vhc_pkg::cfg_t cfg,
  input  logic          hold,
  vhc_in_if.sink        in_ch,
  output logic          push,
  output vhc_pkg::cmd_t push_cmd,
  input  logic          push_ready
);
  import vhc_pkg::*;

  localparam int BIT_W = $clog2(COORD_BITS);

  typedef enum logic [4:0] {
    F_IDLE = 5'b00001,
    F_MUL  = 5'b00010,
    F_CHK  = 5'b00100,
    F_DIV  = 5'b01000,
    F_PUSH = 5'b10000
  } fstate_t;

  fstate_t                      state_r;
  logic signed [COORD_BITS-1:0] x_r, y_r, z_r;
  logic [2:0]                   step_r;
  logic [SQ_W-1:0]              prod_r;
  logic [R2_W-1:0]              r2_r;
  logic [SQ_W-1:0]              min2_r, max2_r;
  cmd_t                         cmd_r;
  logic [1:0]                   coord_r;
  logic [BIT_W-1:0]             bit_r;
  logic [COORD_BITS-1:0]        dvd_r, quo_r;
  logic [VSIZE_W-1:0]           rem_r;
  logic                         neg_r;

  logic                         take;
  logic [MUL_W-1:0]             mul_a;
  logic [VSIZE_W-1:0]           dsr;
  logic [VSIZE_W:0]             rem_sh;
  logic                         qbit;
  logic [VSIZE_W-1:0]           rem_n;
  logic [COORD_BITS-1:0]        q_fin, key;
  logic signed [COORD_BITS-1:0] nxt_coord;
  logic                         last_bit;

  function automatic logic [MUL_W-1:0] mag(input logic signed [COORD_BITS-1:0] v);
    logic [COORD_BITS-1:0] u;
    u = v[COORD_BITS-1] ? (~v + 1'b1) : v;
    return MUL_W'(u);
  endfunction

  assign take         = in_ch.valid && in_ch.ready;
  assign in_ch.ready  = (state_r == F_IDLE) && !hold;
  assign push         = (state_r == F_PUSH);
  assign push_cmd     = cmd_r;

  // multiplier operand per step: x, y, z, then the two range limits
  always_comb begin
    case (step_r)
      3'd0:    mul_a = mag(x_r);
      3'd1:    mul_a = mag(y_r);
      3'd2:    mul_a = mag(z_r);
      3'd3:    mul_a = MUL_W'(cfg.min_range_mm);
      3'd4:    mul_a = MUL_W'(cfg.max_range_mm);
      default: mul_a = '0;
    endcase
  end

  // one restoring division step on the magnitude, floor correction on the last one
  always_comb begin
    dsr       = (cfg.voxel_size_mm == '0) ? VSIZE_W'(1) : cfg.voxel_size_mm;
    rem_sh    = {rem_r, dvd_r[COORD_BITS-1]};
    qbit      = (rem_sh >= {1'b0, dsr});
    rem_n     = qbit ? VSIZE_W'(rem_sh - {1'b0, dsr}) : rem_sh[VSIZE_W-1:0];
    q_fin     = {quo_r[COORD_BITS-2:0], qbit};
    key       = neg_r ? (~(q_fin + COORD_BITS'(rem_n != '0)) + 1'b1) : q_fin;
    nxt_coord = (coord_r == 2'd0) ? y_r : z_r;
    last_bit  = (bit_r == BIT_W'(COORD_BITS - 1));
  end

  // control sequence
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= F_IDLE;
    end else begin
      case (state_r)
        F_IDLE: begin
          if (take) begin
            if (in_ch.operation || !cfg.filter_enable) begin
              state_r <= F_PUSH;
            end else begin
              state_r <= F_MUL;
            end
          end
        end
        F_MUL: begin
          if (step_r == 3'd5) begin
            state_r <= F_CHK;
          end
        end
        F_CHK: begin
          if (r2_r < R2_W'(min2_r) || r2_r > R2_W'(max2_r)) begin
            state_r <= F_PUSH;
          end else begin
            state_r <= F_DIV;
          end
        end
        F_DIV: begin
          if (last_bit && coord_r == 2'd2) begin
            state_r <= F_PUSH;
          end
        end
        F_PUSH: begin
          if (push_ready) begin
            state_r <= F_IDLE;
          end
        end
        default: state_r <= F_IDLE;
      endcase
    end
  end

  // datapath
  always_ff @(posedge clk) begin
    case (state_r)
      F_IDLE: begin
        if (take) begin
          x_r          <= in_ch.point_x;
          y_r          <= in_ch.point_y;
          z_r          <= in_ch.point_z;
          step_r       <= '0;
          r2_r         <= '0;
          cmd_r.key_x  <= '0;
          cmd_r.key_y  <= '0;
          cmd_r.key_z  <= '0;
          cmd_r.keep   <= !in_ch.operation && !cfg.filter_enable;
          cmd_r.kind   <= in_ch.operation ? CMD_FRAME : CMD_PASS;
        end
      end
      F_MUL: begin
        if (step_r != 3'd5) begin
          prod_r <= mul_a * mul_a;
        end
        case (step_r)
          3'd1, 3'd2, 3'd3: r2_r   <= r2_r + R2_W'(prod_r);
          3'd4:             min2_r <= prod_r;
          3'd5:             max2_r <= prod_r;
          default:          ;
        endcase
        step_r <= step_r + 3'd1;
      end
      F_CHK: begin
        cmd_r.keep <= cfg.shadow_en;
        coord_r    <= 2'd0;
        bit_r      <= '0;
        dvd_r      <= COORD_BITS'(mag(x_r));
        neg_r      <= x_r[COORD_BITS-1];
        quo_r      <= '0;
        rem_r      <= '0;
      end
      F_DIV: begin
        dvd_r <= {dvd_r[COORD_BITS-2:0], 1'b0};
        quo_r <= q_fin;
        rem_r <= rem_n;
        bit_r <= bit_r + 1'b1;
        if (last_bit) begin
          case (coord_r)
            2'd0:    cmd_r.key_x <= key;
            2'd1:    cmd_r.key_y <= key;
            default: cmd_r.key_z <= key;
          endcase
          // next coordinate
          coord_r <= coord_r + 2'd1;
          bit_r   <= '0;
          dvd_r   <= COORD_BITS'(mag(nxt_coord));
          neg_r   <= nxt_coord[COORD_BITS-1];
          quo_r   <= '0;
          rem_r   <= '0;
          if (coord_r == 2'd2) begin
            cmd_r.kind <= CMD_POINT;
          end
        end
      end
      default: ;
    endcase
  end

endmodule

FILE: rtl/vhc_fifo.sv
// short command queue between the front end and the table engine
`timescale 1ns / 1ps
module vhc_fifo (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          push,
  input  vhc_pkg::cmd_t push_cmd,
  output logic          push_ready,
  output logic          pop_valid,
  output vhc_pkg::cmd_t pop_cmd,
  input  logic          pop
);
  import vhc_pkg::*;

  cmd_t                  mem_r [FIFO_DEPTH];
  logic [FIFO_PTR_W-1:0] wr_ptr_r, rd_ptr_r;
  logic [FIFO_CNT_W-1:0] count_r;
  logic                  do_push, do_pop;

  assign push_ready = (count_r != FIFO_CNT_W'(FIFO_DEPTH));
  assign pop_valid  = (count_r != '0);
  assign pop_cmd    = mem_r[rd_ptr_r];
  assign do_push    = push && push_ready;
  assign do_pop     = pop && pop_valid;

  // pointers and fill level
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr_r <= wr_ptr_r + 1'b1;
      end
      if (do_pop) begin
        rd_ptr_r <= rd_ptr_r + 1'b1;
      end
      if (do_push && !do_pop) begin
        count_r <= count_r + 1'b1;
      end else if (do_pop && !do_push) begin
        count_r <= count_r - 1'b1;
      end
    end
  end

  // storage
  always_ff @(posedge clk) begin
    if (do_push) begin
      mem_r[wr_ptr_r] <= push_cmd;
    end
  end

endmodule

FILE: rtl/vhc_back.sv
// table engine: voxel store, lookup scan, stale and least recently used eviction
`timescale 1ns / 1ps
module vhc_back (
  input  logic          clk,
  input  logic          rst_n,
  input  vhc_pkg::cfg_t cfg,
  input  logic          pop_valid,
  input  vhc_pkg::cmd_t pop_cmd,
  output logic          pop,
  output logic          clearing,
  vhc_out_if.source     out_ch
);
  import vhc_pkg::*;

  typedef enum logic [7:0] {
    B_CLEAR = 8'b00000001,
    B_IDLE  = 8'b00000010,
    B_LOOK  = 8'b00000100,
    B_UPD   = 8'b00001000,
    B_STALE = 8'b00010000,
    B_CAP   = 8'b00100000,
    B_LRU   = 8'b01000000,
    B_EVICT = 8'b10000000
  } bstate_t;

  typedef struct packed {
    logic             keep_point;
    logic             is_static;
    logic             in_range;
    logic [HIT_W-1:0] hit_count;
    logic             table_full;
    logic [CAP_W-1:0] evicted_count;
  } res_t;

  entry_t             mem [TABLE_DEPTH];
  entry_t             mem_q_r;

  bstate_t            state_r;
  logic [CNT_W-1:0]   cnt_r;
  logic               rd_v_r;
  logic [IDX_W-1:0]   rd_idx_r;
  logic               out_valid_r;
  logic [FRAME_W-1:0] frame_r;
  logic [TOUCH_W-1:0] touch_r;
  logic [CNT_W-1:0]   total_r;
  logic [CNT_W-1:0]   evicted_r;
  cmd_t               cmd_r;
  logic               found_r, free_r, best_v_r;
  logic [IDX_W-1:0]   slot_r, free_idx_r, best_idx_r;
  logic [HIT_W-1:0]   hits_r;
  logic [TOUCH_W-1:0] best_touch_r;
  res_t               res_r;

  logic               take, issue, scan_end, key_hit, stale_hit, over_cap, full;
  logic [IDX_W-1:0]   rd_addr, wr_addr, upd_slot;
  logic               we;
  entry_t             wr_data;
  logic [FRAME_W-1:0] age_limit;
  logic [HIT_W-1:0]   old_hits, new_hits, res_hits;
  logic [TOUCH_W-1:0] touch_nxt;
  logic               res_static;
  res_t               frame_res;

  assign clearing             = (state_r == B_CLEAR);
  assign take                 = (state_r == B_IDLE) && pop_valid && (!out_valid_r || out_ch.ready);
  assign pop                  = take;
  assign out_ch.valid         = out_valid_r;
  assign out_ch.keep_point    = res_r.keep_point;
  assign out_ch.is_static     = res_r.is_static;
  assign out_ch.in_range      = res_r.in_range;
  assign out_ch.hit_count     = res_r.hit_count;
  assign out_ch.table_full    = res_r.table_full;
  assign out_ch.evicted_count = res_r.evicted_count;

  // scan address generation and per-entry decisions
  always_comb begin
    rd_addr      = cnt_r[IDX_W-1:0];
    issue        = (state_r == B_LOOK || state_r == B_STALE || state_r == B_LRU) &&
                   (cnt_r < CNT_W'(TABLE_DEPTH));
    scan_end     = (cnt_r == CNT_W'(TABLE_DEPTH)) && !rd_v_r;
    key_hit      = mem_q_r.valid && mem_q_r.key_x == cmd_r.key_x &&
                   mem_q_r.key_y == cmd_r.key_y && mem_q_r.key_z == cmd_r.key_z;
    age_limit    = (frame_r > FRAME_W'(STALE_FRAMES)) ? frame_r - FRAME_W'(STALE_FRAMES) : '0;
    stale_hit    = (state_r == B_STALE) && rd_v_r && mem_q_r.valid &&
                   (mem_q_r.last_frame < age_limit);
    over_cap     = CMP_W'(total_r) > CMP_W'(cfg.voxel_capacity);
  end

  // point update: found entry, first free slot, or store full
  always_comb begin
    full       = !found_r && !free_r;
    upd_slot   = found_r ? slot_r : free_idx_r;
    old_hits   = found_r ? hits_r : '0;
    new_hits   = (old_hits < HIT_SAT) ? old_hits + 1'b1 : old_hits;
    res_hits   = full ? '0 : new_hits;
    res_static = (res_hits >= cfg.min_static_count);
    touch_nxt  = touch_r + 1'b1;
    frame_res               = '0;
    frame_res.evicted_count = CAP_W'(evicted_r);
  end

  // memory write port
  always_comb begin
    we      = 1'b0;
    wr_addr = rd_idx_r;
    wr_data = '0;
    case (state_r)
      B_CLEAR: begin
        we      = 1'b1;
        wr_addr = cnt_r[IDX_W-1:0];
      end
      B_UPD: begin
        we      = !full;
        wr_addr = upd_slot;
        wr_data = '{valid: 1'b1, key_x: cmd_r.key_x, key_y: cmd_r.key_y,
                    key_z: cmd_r.key_z, hits: new_hits, last_frame: frame_r,
                    touch: touch_nxt};
      end
      B_STALE: begin
        we            = stale_hit;
        wr_data       = mem_q_r;
        wr_data.valid = 1'b0;
      end
      B_EVICT: begin
        we      = 1'b1;
        wr_addr = best_idx_r;
      end
      default: ;
    endcase
  end

  // voxel store
  always_ff @(posedge clk) begin
    mem_q_r <= mem[rd_addr];
    if (we) begin
      mem[wr_addr] <= wr_data;
    end
  end

  // control state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= B_CLEAR;
      cnt_r       <= '0;
      rd_v_r      <= 1'b0;
      out_valid_r <= 1'b0;
      frame_r     <= FRAME_W'(1);
      touch_r     <= '0;
      total_r     <= '0;
    end else begin
      rd_v_r <= issue;
      if (issue) begin
        cnt_r <= cnt_r + 1'b1;
      end
      if (out_ch.ready) begin
        out_valid_r <= 1'b0;
      end
      case (state_r)
        B_CLEAR: begin
          cnt_r <= cnt_r + 1'b1;
          if (cnt_r == CNT_W'(TABLE_DEPTH - 1)) begin
            state_r <= B_IDLE;
          end
        end
        B_IDLE: begin
          if (take) begin
            cnt_r <= '0;
            case (pop_cmd.kind)
              CMD_POINT: state_r <= B_LOOK;
              CMD_FRAME: state_r <= B_STALE;
              default:   out_valid_r <= 1'b1;
            endcase
          end
        end
        B_LOOK: begin
          if (scan_end) begin
            state_r <= B_UPD;
          end
        end
        B_UPD: begin
          if (!full) begin
            touch_r <= touch_nxt;
            if (!found_r) begin
              total_r <= total_r + 1'b1;
            end
          end
          out_valid_r <= 1'b1;
          state_r     <= B_IDLE;
        end
        B_STALE: begin
          if (stale_hit) begin
            total_r <= total_r - 1'b1;
          end
          if (scan_end) begin
            state_r <= B_CAP;
          end
        end
        B_CAP: begin
          if (over_cap) begin
            cnt_r   <= '0;
            state_r <= B_LRU;
          end else begin
            frame_r     <= frame_r + 1'b1;
            out_valid_r <= 1'b1;
            state_r     <= B_IDLE;
          end
        end
        B_LRU: begin
          if (scan_end) begin
            if (best_v_r) begin
              state_r <= B_EVICT;
            end else begin
              frame_r     <= frame_r + 1'b1;
              out_valid_r <= 1'b1;
              state_r     <= B_IDLE;
            end
          end
        end
        B_EVICT: begin
          total_r <= total_r - 1'b1;
          state_r <= B_CAP;
        end
        default: state_r <= B_IDLE;
      endcase
    end
  end

  // scan results and result register
  always_ff @(posedge clk) begin
    case (state_r)
      B_IDLE: begin
        if (take) begin
          cmd_r     <= pop_cmd;
          found_r   <= 1'b0;
          free_r    <= 1'b0;
          best_v_r  <= 1'b0;
          evicted_r <= '0;
          if (pop_cmd.kind == CMD_PASS) begin
            res_r            <= '0;
            res_r.keep_point <= pop_cmd.keep;
          end
        end
      end
      B_LOOK: begin
        if (rd_v_r) begin
          // first matching entry and first free slot in index order
          if (key_hit && !found_r) begin
            found_r <= 1'b1;
            slot_r  <= rd_idx_r;
            hits_r  <= mem_q_r.hits;
          end
          if (!mem_q_r.valid && !free_r) begin
            free_r     <= 1'b1;
            free_idx_r <= rd_idx_r;
          end
        end
      end
      B_UPD: begin
        res_r <= '{keep_point: cfg.shadow_en || res_static, is_static: res_static,
                   in_range: 1'b1, hit_count: res_hits, table_full: full,
                   evicted_count: '0};
      end
      B_STALE: begin
        if (stale_hit) begin
          evicted_r <= evicted_r + 1'b1;
        end
      end
      B_CAP: begin
        if (over_cap) begin
          best_v_r <= 1'b0;
        end else begin
          res_r <= frame_res;
        end
      end
      B_LRU: begin
        // oldest stamp wins, strict compare keeps the lowest index on ties
        if (rd_v_r && mem_q_r.valid && (!best_v_r || mem_q_r.touch < best_touch_r)) begin
          best_v_r     <= 1'b1;
          best_idx_r   <= rd_idx_r;
          best_touch_r <= mem_q_r.touch;
        end
        if (scan_end && !best_v_r) begin
          res_r <= frame_res;
        end
      end
      B_EVICT: begin
        evicted_r <= evicted_r + 1'b1;
      end
      default: ;
    endcase
    rd_idx_r <= rd_addr;
  end

endmodule

FILE: rtl/voxel_hit_count_static_point_filter.sv
// top level of the voxel hit-count static point filter
`timescale 1ns / 1ps
// Points and frame-end transactions enter on in_ch and each yields one result transaction
// on out_ch. A front end checks the squared range with one shared multiplier and forms
// the three voxel keys with a one-bit-per-cycle divider; a two-entry command queue
// decouples it from the table engine. The engine holds the 4096 entry voxel store in a
// single-port-read, single-port-write memory and scans it one entry per cycle: a point
// costs one full scan in the engine, a frame end one scan for the stale pass plus one
// full least recently used search for each entry evicted by capacity. Disabled and
// out-of-range points pass the engine without a scan. After reset a clearing pass runs
// over all 4096 entries of the store and in_ch.ready stays low until it finishes;
// configuration writes are taken at any time.
module voxel_hit_count_static_point_filter (
  input  logic                             clk,
  input  logic                             rst_n,
  vhc_in_if.sink                           in_ch,
  vhc_out_if.source                        out_ch,
  input  logic                             cfg_we,
  input  logic [vhc_pkg::CFG_IDX_W-1:0]    cfg_index,
  input  logic [vhc_pkg::CFG_DATA_W-1:0]   cfg_wdata
);
  import vhc_pkg::*;

  cfg_t cfg_r;
  logic push, push_ready, pop_valid, pop, clearing;
  cmd_t push_cmd, pop_cmd;

  // configuration registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.filter_enable    <= 1'b1;
      cfg_r.shadow_en        <= 1'b0;
      cfg_r.min_static_count <= HIT_W'(1);
      cfg_r.voxel_size_mm    <= VSIZE_W'(200);
      cfg_r.min_range_mm     <= '0;
      cfg_r.max_range_mm     <= RANGE_W'(100000);
      cfg_r.voxel_capacity   <= CAP_W'(4096);
    end else if (cfg_we) begin
      case (cfg_index)
        REG_FILTER_ENABLE:    cfg_r.filter_enable    <= cfg_wdata[0];
        REG_SHADOW_EN:        cfg_r.shadow_en        <= cfg_wdata[0];
        REG_MIN_STATIC_COUNT: cfg_r.min_static_count <= cfg_wdata[HIT_W-1:0];
        REG_VOXEL_SIZE_MM:    cfg_r.voxel_size_mm    <= cfg_wdata[VSIZE_W-1:0];
        REG_MIN_RANGE_MM:     cfg_r.min_range_mm     <= cfg_wdata[RANGE_W-1:0];
        REG_MAX_RANGE_MM:     cfg_r.max_range_mm     <= cfg_wdata[RANGE_W-1:0];
        REG_VOXEL_CAPACITY:   cfg_r.voxel_capacity   <= cfg_wdata[CAP_W-1:0];
        default:              ;
      endcase
    end
  end

  // classification front end
  vhc_front u_front (
    .clk        (clk),
    .rst_n      (rst_n),
    .cfg        (cfg_r),
    .hold       (clearing),
    .in_ch      (in_ch),
    .push       (push),
    .push_cmd   (push_cmd),
    .push_ready (push_ready)
  );

  // command queue
  vhc_fifo u_fifo (
    .clk        (clk),
    .rst_n      (rst_n),
    .push       (push),
    .push_cmd   (push_cmd),
    .push_ready (push_ready),
    .pop_valid  (pop_valid),
    .pop_cmd    (pop_cmd),
    .pop        (pop)
  );

  // voxel table engine
  vhc_back u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg       (cfg_r),
    .pop_valid (pop_valid),
    .pop_cmd   (pop_cmd),
    .pop       (pop),
    .clearing  (clearing),
    .out_ch    (out_ch)
  );

endmodule
